// ===== rtl/uia_pkg.sv =====
// Package: shared types, opcodes and constants for the unsigned integer ALU.
`timescale 1ns / 1ps
package uia_pkg;

  localparam int unsigned DefaultWidth = 32;
  localparam int unsigned OpW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [OpW-1:0] {
    OP_AND   = 5'd0,
    OP_NAND  = 5'd1,
    OP_ANDYN = 5'd2,
    OP_ANDNY = 5'd3,
    OP_XOR   = 5'd4,
    OP_XNOR  = 5'd5,
    OP_OR    = 5'd6,
    OP_ORYN  = 5'd7,
    OP_ORNY  = 5'd8,
    OP_NOR   = 5'd9,
    OP_EQ    = 5'd10,
    OP_MIN   = 5'd11,
    OP_MAX   = 5'd12,
    OP_ADD   = 5'd13,
    OP_INC   = 5'd14,
    OP_SUB   = 5'd15,
    OP_MUL   = 5'd16,
    OP_DIV   = 5'd17,
    OP_REM   = 5'd18
  } op_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             divide_by_zero;
  } out_item_t;

endpackage

// ===== rtl/uia_cell.sv =====
// One cell of the bit-serial chain: one multiply and one restoring divide step.
`timescale 1ns / 1ps
module uia_cell #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned BIT   = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             vld_in,
  input  logic [4:0]       op_in,
  input  logic [WIDTH-1:0] a_in,
  input  logic [WIDTH-1:0] b_in,
  input  logic [WIDTH-1:0] acc_in,
  input  logic [WIDTH-1:0] quo_in,
  input  logic [WIDTH-1:0] rem_in,
  output logic             vld_out,
  output logic [4:0]       op_out,
  output logic [WIDTH-1:0] a_out,
  output logic [WIDTH-1:0] b_out,
  output logic [WIDTH-1:0] acc_out,
  output logic [WIDTH-1:0] quo_out,
  output logic [WIDTH-1:0] rem_out
);
  import uia_pkg::*;

  logic [WIDTH-1:0] acc_next;
  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] quo_next;

  // Add the shifted multiplicand for this multiplier bit; take one divide step
  // The shifted remainder can reach WIDTH+1 bits, so subtract one bit wider
  always_comb begin
    acc_next = acc_in;
    if (b_in[BIT]) begin
      acc_next = acc_in + (a_in << BIT);
    end
    shifted  = {rem_in, a_in[WIDTH-1-BIT]};
    diff     = {1'b0, shifted} - {2'b00, b_in};
    quo_next = quo_in;
    rem_next = shifted[WIDTH-1:0];
    if (!diff[WIDTH+1]) begin
      rem_next = diff[WIDTH-1:0];
      quo_next[WIDTH-1-BIT] = 1'b1;
    end
  end

  // Advance control
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    op_out  <= op_in;
    a_out   <= a_in;
    b_out   <= b_in;
    acc_out <= acc_next;
    quo_out <= quo_next;
    rem_out <= rem_next;
  end
endmodule

// ===== rtl/unsigned_integer_alu_top.sv =====
// Top level: operand register, chain of WIDTH cells, result stage.
// Every opcode takes the same path from start to strobe: operand register, cells, result register.
// Throughput: one item per cycle; busy stays low, no stall.
// The chain holds one multiply add and one divide step per cell.
// Synchronous active-high rst clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
module unsigned_integer_alu_top #(
  parameter int unsigned WIDTH = uia_pkg::DefaultWidth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  uia_pkg::in_item_t  in_item,
  output logic               strobe,
  output uia_pkg::out_item_t out_item
);
  import uia_pkg::*;

  logic             v   [WIDTH+1];
  logic [4:0]       o   [WIDTH+1];
  logic [WIDTH-1:0] a   [WIDTH+1];
  logic [WIDTH-1:0] b   [WIDTH+1];
  logic [WIDTH-1:0] acc [WIDTH+1];
  logic [WIDTH-1:0] quo [WIDTH+1];
  logic [WIDTH-1:0] rem [WIDTH+1];

  logic [WIDTH-1:0] res_next;
  logic             dz_next;
  logic [WIDTH-1:0] ones;

  assign busy = 1'b0;
  assign ones = '1;

  // Capture the item masked to WIDTH
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= start;
    end
  end

  always_ff @(posedge clk) begin
    o[0]   <= in_item.op;
    a[0]   <= WIDTH'(in_item.operand_a);
    b[0]   <= WIDTH'(in_item.operand_b);
    acc[0] <= '0;
    quo[0] <= '0;
    rem[0] <= '0;
  end

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    uia_cell #(.WIDTH(WIDTH), .BIT(i)) u_cell (
      .clk(clk), .rst(rst),
      .vld_in(v[i]), .op_in(o[i]), .a_in(a[i]), .b_in(b[i]),
      .acc_in(acc[i]), .quo_in(quo[i]), .rem_in(rem[i]),
      .vld_out(v[i+1]), .op_out(o[i+1]), .a_out(a[i+1]), .b_out(b[i+1]),
      .acc_out(acc[i+1]), .quo_out(quo[i+1]), .rem_out(rem[i+1])
    );
  end

  // Select the result at the end of the chain
  always_comb begin
    logic [WIDTH-1:0] x;
    logic [WIDTH-1:0] y;
    x = a[WIDTH];
    y = b[WIDTH];
    dz_next = 1'b0;
    unique case (o[WIDTH])
      OP_AND:   res_next = x & y;
      OP_NAND:  res_next = ~(x & y);
      OP_ANDYN: res_next = x & ~y;
      OP_ANDNY: res_next = ~x & y;
      OP_XOR:   res_next = x ^ y;
      OP_XNOR:  res_next = ~(x ^ y);
      OP_OR:    res_next = x | y;
      OP_ORYN:  res_next = x | ~y;
      OP_ORNY:  res_next = ~x | y;
      OP_NOR:   res_next = ~(x | y);
      OP_EQ:    res_next = WIDTH'(x == y);
      OP_MIN:   res_next = (x > y) ? y : x;
      OP_MAX:   res_next = (x > y) ? x : y;
      OP_ADD:   res_next = x + y;
      OP_INC:   res_next = x + WIDTH'(1);
      OP_SUB:   res_next = x - y;
      OP_MUL:   res_next = acc[WIDTH];
      OP_DIV: begin
        dz_next  = (y == '0);
        res_next = dz_next ? ones : quo[WIDTH];
      end
      OP_REM: begin
        dz_next  = (y == '0);
        res_next = dz_next ? x : rem[WIDTH];
      end
      default:  res_next = '0;
    endcase
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= v[WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    out_item.result         <= DataW'(res_next);
    out_item.divide_by_zero <= dz_next;
  end
endmodule

// ===== rtl/uia_checker.sv =====
// Checker: port-level properties of the ALU, bound to the top level.
`timescale 1ns / 1ps
module uia_checker #(
  parameter int unsigned WIDTH = uia_pkg::DefaultWidth
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input uia_pkg::in_item_t  in_item,
  input logic               strobe,
  input uia_pkg::out_item_t out_item
);
  import uia_pkg::*;

  localparam int unsigned Lat = WIDTH + 2;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_strobe_follows: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start, Lat)) else $error("strobe without item");

  a_item_strobes: assert property (@(posedge clk) disable iff (rst)
    start ##Lat !rst |-> strobe) else $error("item lost");

  a_dz_op: assert property (@(posedge clk) disable iff (rst)
    strobe && out_item.divide_by_zero |->
      ($past(in_item.op, Lat) == OP_DIV || $past(in_item.op, Lat) == OP_REM))
    else $error("flag on wrong op");

  a_eq_bool: assert property (@(posedge clk) disable iff (rst)
    strobe && $past(in_item.op, Lat) == OP_EQ |-> out_item.result[DataW-1:1] == '0)
    else $error("eq not boolean");
endmodule

bind unsigned_integer_alu_top uia_checker #(.WIDTH(WIDTH)) u_uia_checker (.*);

// ===== tb/tb_top.sv =====
// Testbench for the unsigned integer ALU: directed table, random ops, scoreboard.
`timescale 1ns / 1ps
module tb_top;
  import uia_pkg::*;

  localparam int unsigned Latency = DefaultWidth + 2;
  localparam int unsigned WatchLimit = 4000;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      strobe;
  out_item_t out_item;

  out_item_t alu_results_q[$];
  int        mismatches;
  int        idle_cycles;
  int        send_idle_pct;

  typedef struct {
    in_item_t  item;
    logic      known;
    out_item_t want;
  } table_row_t;

  unsigned_integer_alu_top #(.WIDTH(DefaultWidth)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_item(in_item), .strobe(strobe), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Compute the result of one item with 32-bit wrapping arithmetic.
  function automatic out_item_t alu_compute(input in_item_t it);
    out_item_t   o;
    logic [31:0] a, b, q, r;
    logic [32:0] rr;
    a = it.operand_a;
    b = it.operand_b;
    o.divide_by_zero = 1'b0;
    o.result = '0;
    case (it.op)
      OP_AND:   o.result = a & b;
      OP_NAND:  o.result = ~(a & b);
      OP_ANDYN: o.result = a & ~b;
      OP_ANDNY: o.result = ~a & b;
      OP_XOR:   o.result = a ^ b;
      OP_XNOR:  o.result = ~(a ^ b);
      OP_OR:    o.result = a | b;
      OP_ORYN:  o.result = a | ~b;
      OP_ORNY:  o.result = ~a | b;
      OP_NOR:   o.result = ~(a | b);
      OP_EQ:    o.result = (a == b) ? 32'd1 : 32'd0;
      OP_MIN:   o.result = (a > b) ? b : a;
      OP_MAX:   o.result = (a > b) ? a : b;
      OP_ADD:   o.result = a + b;
      OP_INC:   o.result = a + 32'd1;
      OP_SUB:   o.result = a - b;
      OP_MUL:   o.result = a * b;
      OP_DIV, OP_REM: begin
        if (b == 0) begin
          o.divide_by_zero = 1'b1;
          o.result = (it.op == OP_DIV) ? 32'hFFFF_FFFF : a;
        end else begin
          // Restoring division, one quotient bit per step
          r = '0;
          q = '0;
          for (int i = 31; i >= 0; i--) begin
            rr = {r, a[i]};
            if (rr >= {1'b0, b}) begin
              rr = rr - {1'b0, b};
              q[i] = 1'b1;
            end
            r = rr[31:0];
          end
          o.result = (it.op == OP_DIV) ? q : r;
        end
      end
      default:  o.result = '0;
    endcase
    return o;
  endfunction

  // Check every strobed item against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (alu_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_item);
      end else begin
        if (out_item.result !== alu_results_q[0].result ||
            out_item.divide_by_zero !== alu_results_q[0].divide_by_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b got %h/%b",
                     alu_results_q[0].result, alu_results_q[0].divide_by_zero,
                     out_item.result, out_item.divide_by_zero);
        end
        void'(alu_results_q.pop_front());
      end
    end
  end

  // Count cycles with nothing accepted or strobed; end the run at the limit.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Drive one item at the falling edge and hold until accepted; start stays
  // high afterwards so the next item can follow without a gap.
  task automatic send_item(input in_item_t it, input logic known, input out_item_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    alu_results_q = {alu_results_q, (known ? want : alu_compute(it))};
    @(negedge clk);
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    logic [31:0] v [2];
    for (int k = 0; k < 2; k++) begin
      case ($urandom_range(5))
        0: v[k] = '0;
        1: v[k] = 32'hFFFF_FFFF;
        2: v[k] = $urandom_range(15);
        3: v[k] = 32'd1 << $urandom_range(31);
        default: v[k] = $urandom;
      endcase
    end
    it.op = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 19))
                                     : 5'($urandom_range(OP_REM));
    it.operand_a = v[0];
    it.operand_b = v[1];
    return it;
  endfunction

  table_row_t rows[$];
  out_item_t  w;
  in_item_t   it;

  // Append one row to the directed table.
  task automatic add_row(input in_item_t item, input logic known, input out_item_t want);
    table_row_t row;
    row.item  = item;
    row.known = known;
    row.want  = want;
    rows = {rows, row};
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    mismatches = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: extremes, every opcode, zero divisor, unused opcodes
    add_row('{OP_AND, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, '{32'hFFFF_FFFF, 0});
    add_row('{OP_NAND, 32'h0, 32'h0}, 1, '{32'hFFFF_FFFF, 0});
    add_row('{OP_ANDYN, 32'hF0F0_1234, 32'h0FF0_00FF}, 0, '{0, 0});
    add_row('{OP_ANDNY, 32'hF0F0_1234, 32'h0FF0_00FF}, 0, '{0, 0});
    add_row('{OP_XOR, 32'hAAAA_AAAA, 32'h5555_5555}, 1, '{32'hFFFF_FFFF, 0});
    add_row('{OP_XNOR, 32'h1234_5678, 32'h8765_4321}, 0, '{0, 0});
    add_row('{OP_OR, 32'h0, 32'h0}, 1, '{32'h0, 0});
    add_row('{OP_ORYN, 32'h0, 32'hFFFF_FFFF}, 1, '{32'h0, 0});
    add_row('{OP_ORNY, 32'hFFFF_FFFF, 32'h0}, 1, '{32'h0, 0});
    add_row('{OP_NOR, 32'h0, 32'h0}, 1, '{32'hFFFF_FFFF, 0});
    add_row('{OP_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, '{32'd1, 0});
    add_row('{OP_EQ, 32'h0, 32'h1}, 1, '{32'd0, 0});
    add_row('{OP_MIN, 32'hFFFF_FFFF, 32'h0}, 1, '{32'h0, 0});
    add_row('{OP_MAX, 32'hFFFF_FFFF, 32'h0}, 1, '{32'hFFFF_FFFF, 0});
    add_row('{OP_ADD, 32'hFFFF_FFFF, 32'h1}, 1, '{32'h0, 0});
    add_row('{OP_INC, 32'hFFFF_FFFF, 32'h1234_5678}, 1, '{32'h0, 0});
    add_row('{OP_SUB, 32'h0, 32'h1}, 1, '{32'hFFFF_FFFF, 0});
    add_row('{OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, '{32'h1, 0});
    add_row('{OP_DIV, 32'hFFFF_FFFF, 32'h1}, 1, '{32'hFFFF_FFFF, 0});
    add_row('{OP_DIV, 32'h1234_5678, 32'h0}, 1, '{32'hFFFF_FFFF, 1});
    add_row('{OP_REM, 32'h1234_5678, 32'h0}, 1, '{32'h1234_5678, 1});
    add_row('{OP_DIV, 32'hFFFF_FFFF, 32'h8000_0001}, 0, '{0, 0});
    add_row('{OP_REM, 32'hFFFF_FFFE, 32'hFFFF_FFFF}, 1, '{32'hFFFF_FFFE, 0});
    add_row('{5'd19, 32'hFFFF_FFFF, 32'h0}, 1, '{32'h0, 0});
    add_row('{5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, '{32'h0, 0});
    foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].want);

    // Random phases with varying sender idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: send_idle_pct = 0;
        1: send_idle_pct = 82;
        2: send_idle_pct = 10;
        default: send_idle_pct = 0;
      endcase
      for (int n = 0; n < 260; n++) begin
        it = rand_item();
        send_item(it, 1'b0, w);
      end
      // After the second phase, hold off until the pipeline drains
      if (ph == 1) begin
        start <= 1'b0;
        while (alu_results_q.size() != 0) @(posedge clk);
        @(negedge clk);
      end
    end

    start <= 1'b0;
    while (alu_results_q.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    if (mismatches == 0 && alu_results_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
